// File: rtl/projected_pair_sign_test_assert.svh
// Assertion macros for the projected pair sign test RTL
`ifndef PROJECTED_PAIR_SIGN_TEST_ASSERT_SVH
`define PROJECTED_PAIR_SIGN_TEST_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pst_pkg.sv
// Shared constants, opcodes and pipeline tag type of the projected pair sign test
package pst_pkg;
  localparam int MAX_DIM_DEF = 16;
  localparam int VW = 16;
  localparam int DW = 5;
  localparam logic [DW-1:0] DIM_RESET = 5'd16;

  localparam logic [1:0] OP_INV  = 2'd0;
  localparam logic [1:0] OP_CON  = 2'd1;
  localparam logic [1:0] OP_PAIR = 2'd2;

  typedef struct packed {
    logic vld;
    logic first;
    logic fin;
    logic ph2;
    logic top_row;
  } pst_tag_t;
endpackage

// File: rtl/projected_pair_sign_test.sv
// Top level: matrix and pair stores, evaluation sequencer, two MAC lanes and merge
//
//  channel | ports                          | word contents (low bit up)
//  --------+--------------------------------+---------------------------------------
//  in      | in_tvalid in_tready in_tdata   | operation, index, value_even, value_odd
//          | in_tlast                       | last
//  out     | out_tvalid out_tready out_tdata| verdict
//  cfg     | cfg_valid cfg_ready cfg_data   | dimension_in_use
//
// Matrix writes and non-last pair words are accepted while the sequencer is idle.
// A last pair word runs k*k MAC steps for x, then 2(k-2)*k steps for w, on two
// lanes (one per vector) with one memory read port per store; the verdict word
// is registered in the response state, once the lanes have drained.
// Reset (rst_n low, synchronous) sets k to 16 and empties the pipeline.
// A stalled verdict word holds; only a further last pair word waits for it.
`include "projected_pair_sign_test_assert.svh"
module projected_pair_sign_test import pst_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // operation[1:0], index[10:2], value_even[26:11],
                                    // value_odd[42:27]
  input  logic          in_tlast,   // last
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,  // verdict[0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [DW-1:0] cfg_data    // dimension_in_use
);
  localparam int INV_DEPTH = MAX_DIM * MAX_DIM;
  localparam int CON_DEPTH = MAX_DIM * 2 * (MAX_DIM - 2);
  localparam int IAW = $clog2(INV_DEPTH);
  localparam int CAW = $clog2(CON_DEPTH);
  localparam int PAW = $clog2(MAX_DIM);
  localparam int KW  = $clog2(MAX_DIM + 1);
  localparam int CW  = KW + 1;
  localparam int XW  = 2 * VW + PAW + 1;
  localparam int SW  = XW + VW + PAW + 1;

  typedef enum logic [2:0] {S_IDLE, S_P1, S_D1, S_P2, S_D2, S_RESP} state_t;

  logic [1:0]    op;
  logic [8:0]    idx;
  logic [VW-1:0] ve, vo;
  assign op  = in_tdata[1:0];
  assign idx = in_tdata[10:2];
  assign ve  = in_tdata[26:11];
  assign vo  = in_tdata[42:27];

  logic [VW-1:0]   inv_mem  [INV_DEPTH];
  logic [VW-1:0]   con_mem  [CON_DEPTH];
  logic [2*VW-1:0] pair_mem [MAX_DIM];
  logic [XW-1:0]   xe_mem   [MAX_DIM];
  logic [XW-1:0]   xo_mem   [MAX_DIM];

  state_t        state_r;
  logic [DW-1:0] dim_r;
  logic [CW-1:0] i_r;
  logic [KW-1:0] j_r;
  logic [IAW-1:0] ia_r;
  logic [CAW-1:0] ca_r;
  logic [1:0]    drn_r;
  logic          out_tvalid_r;
  logic          out_verdict_r;

  logic [KW-1:0] k;
  logic [CW-1:0] cols;
  logic          in_acc, start, verdict, x_we;
  pst_tag_t      tag_iss, tag_s1_r, tag_e, tag_o_w;

  logic [VW-1:0]   inv_q, con_q;
  logic [2*VW-1:0] pair_q;
  logic [XW-1:0]   xe_q, xo_q;
  logic [CW-1:0]   i_s1_r, i_m_r, i_a_r;
  logic signed [XW-1:0] opa_e, opa_o;
  logic signed [VW-1:0] opb;
  logic signed [SW-1:0] acc_e, acc_o;

  always_comb begin
    if (dim_r < DW'(2)) begin
      k = KW'(2);
    end else if (int'(dim_r) > MAX_DIM) begin
      k = KW'(MAX_DIM);
    end else begin
      k = KW'(dim_r);
    end
    cols = {k, 1'b0} - CW'(4);
  end

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) &&
                     !(out_tvalid_r && in_tlast && (op == OP_PAIR));
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && (op == OP_PAIR) && in_tlast;

  always_comb begin
    tag_iss = '0;
    if (state_r == S_P1) begin
      tag_iss.vld     = 1'b1;
      tag_iss.first   = (j_r == '0);
      tag_iss.fin     = (j_r == k - KW'(1));
      tag_iss.top_row = (i_r == CW'(k) - CW'(1));
    end else if (state_r == S_P2) begin
      tag_iss.vld   = 1'b1;
      tag_iss.ph2   = 1'b1;
      tag_iss.first = (j_r == '0);
      tag_iss.fin   = (j_r == k - KW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dim_r        <= DIM_RESET;
      i_r          <= '0;
      j_r          <= '0;
      ia_r         <= '0;
      ca_r         <= '0;
      drn_r        <= '0;
      out_tvalid_r <= 1'b0;
      tag_s1_r     <= '0;
    end else begin
      tag_s1_r <= tag_iss;
      if (cfg_valid && cfg_ready) begin
        dim_r <= cfg_data;
      end
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_P1;
            i_r     <= '0;
            j_r     <= '0;
            ia_r    <= '0;
          end
        end
        S_P1: begin
          if (j_r == k - KW'(1)) begin
            j_r  <= '0;
            ia_r <= IAW'(i_r + CW'(1));
            i_r  <= i_r + CW'(1);
            if (i_r == CW'(k) - CW'(1)) begin
              state_r <= S_D1;
              drn_r   <= '0;
            end
          end else begin
            j_r  <= j_r + KW'(1);
            ia_r <= ia_r + IAW'(k);
          end
        end
        S_D1: begin
          drn_r <= drn_r + 2'd1;
          if (drn_r == 2'd3) begin
            i_r  <= '0;
            j_r  <= '0;
            ca_r <= '0;
            state_r <= (cols == '0) ? S_RESP : S_P2;
          end
        end
        S_P2: begin
          if (j_r == k - KW'(1)) begin
            j_r  <= '0;
            ca_r <= CAW'(i_r + CW'(1));
            i_r  <= i_r + CW'(1);
            if (i_r == cols - CW'(1)) begin
              state_r <= S_D2;
              drn_r   <= '0;
            end
          end else begin
            j_r  <= j_r + KW'(1);
            ca_r <= ca_r + CAW'(cols);
          end
        end
        S_D2: begin
          drn_r <= drn_r + 2'd1;
          if (drn_r == 2'd3) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          out_tvalid_r  <= 1'b1;
          out_verdict_r <= verdict;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_INV) && (int'(idx) < INV_DEPTH)) begin
      inv_mem[IAW'(idx)] <= ve;
    end
    if (in_acc && (op == OP_CON) && (int'(idx) < CON_DEPTH)) begin
      con_mem[CAW'(idx)] <= ve;
    end
    if (in_acc && (op == OP_PAIR) && (int'(idx) < MAX_DIM)) begin
      pair_mem[PAW'(idx)] <= {vo, ve};
    end
    if (x_we) begin
      xe_mem[PAW'(i_a_r)] <= acc_e[XW-1:0];
      xo_mem[PAW'(i_a_r)] <= acc_o[XW-1:0];
    end
    inv_q  <= inv_mem[ia_r];
    con_q  <= con_mem[ca_r];
    pair_q <= pair_mem[PAW'(j_r)];
    xe_q   <= xe_mem[PAW'(j_r)];
    xo_q   <= xo_mem[PAW'(j_r)];
    i_s1_r <= i_r;
    i_m_r  <= i_s1_r;
    i_a_r  <= i_m_r;
  end

  assign x_we = tag_e.vld && tag_e.fin && !tag_e.ph2;

  always_comb begin
    opa_e = tag_s1_r.ph2 ? xe_q : {{(XW-VW){pair_q[VW-1]}}, pair_q[VW-1:0]};
    opa_o = tag_s1_r.ph2 ? xo_q : {{(XW-VW){pair_q[2*VW-1]}}, pair_q[2*VW-1:VW]};
    opb   = tag_s1_r.ph2 ? con_q : inv_q;
  end

  pst_lane #(.AW(XW), .SW(SW)) u_lane_e (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (tag_s1_r),
    .opa   (opa_e),
    .opb   (opb),
    .tag_o (tag_e),
    .acc_o (acc_e)
  );

  pst_lane #(.AW(XW), .SW(SW)) u_lane_o (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (tag_s1_r),
    .opa   (opa_o),
    .opb   (opb),
    .tag_o (tag_o_w),
    .acc_o (acc_o)
  );

  pst_merge #(.SW(SW)) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (start),
    .tag     (tag_e),
    .acc_e   (acc_e),
    .acc_o   (acc_o),
    .verdict (verdict)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_verdict_r};

  `PST_ASSERT_IMP(a_lanes_lockstep, 1'b1, tag_e == tag_o_w, "MAC lanes out of step")
  `PST_ASSERT_IMP(a_out_from_resp, $rose(out_tvalid_r), $past(state_r == S_RESP), "verdict word without evaluation")
  `PST_ASSERT_IMP(a_x_row_range, x_we, i_a_r < CW'(k), "x row beyond dimension")
  `PST_ASSERT_NXT(a_start_issue, start, state_r == S_P1, "evaluation did not start")
endmodule

// File: rtl/pst_lane.sv
// Multiply-accumulate lane: registered product, then running dot-product sum
module pst_lane import pst_pkg::*; #(
  parameter int AW = 37,
  parameter int SW = 58
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pst_tag_t             tag_i,
  input  logic signed [AW-1:0] opa,
  input  logic signed [VW-1:0] opb,
  output pst_tag_t             tag_o,
  output logic signed [SW-1:0] acc_o
);
  localparam int PW = AW + VW;

  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] acc_r, acc_nxt;
  pst_tag_t             tag_m_r, tag_a_r;

  always_comb begin
    acc_nxt = (tag_m_r.first ? '0 : acc_r) + {{(SW-PW){prod_r[PW-1]}}, prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_m_r <= '0;
      tag_a_r <= '0;
    end else begin
      tag_m_r <= tag_i;
      tag_a_r <= tag_m_r;
    end
    prod_r <= opa * opb;
    if (tag_m_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign tag_o = tag_a_r;
  assign acc_o = acc_r;
endmodule

// File: rtl/pst_merge.sv
// Merge stage: capture the signs of r and r1, flag any positive sign product
module pst_merge import pst_pkg::*; #(
  parameter int SW = 58
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  pst_tag_t             tag,
  input  logic signed [SW-1:0] acc_e,
  input  logic signed [SW-1:0] acc_o,
  output logic                 verdict
);
  logic re_pos_r, re_neg_r, ro_pos_r, ro_neg_r, bad_r;
  logic e_pos, e_neg, o_pos, o_neg, conflict;

  always_comb begin
    e_pos    = !acc_e[SW-1] && (|acc_e);
    e_neg    = acc_e[SW-1];
    o_pos    = !acc_o[SW-1] && (|acc_o);
    o_neg    = acc_o[SW-1];
    conflict = (re_pos_r && e_pos) || (re_neg_r && e_neg) ||
               (ro_pos_r && o_pos) || (ro_neg_r && o_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_pos_r <= 1'b0;
      re_neg_r <= 1'b0;
      ro_pos_r <= 1'b0;
      ro_neg_r <= 1'b0;
      bad_r    <= 1'b0;
    end else if (clear) begin
      bad_r <= 1'b0;
    end else if (tag.vld && tag.fin) begin
      if (tag.ph2 && conflict) begin
        bad_r <= 1'b1;
      end
      if (!tag.ph2 && tag.top_row) begin
        re_pos_r <= e_pos;
        re_neg_r <= e_neg;
        ro_pos_r <= o_pos;
        ro_neg_r <= o_neg;
      end
    end
  end

  assign verdict = !bad_r;
endmodule

// File: tb/projected_pair_sign_test_test.sv
// Testbench for projected_pair_sign_test: matrix loads and vector pairs against a sign-test predictor
module projected_pair_sign_test_test;
  import pst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXD = 16;
  localparam int INV_N = MAXD * MAXD;
  localparam int CON_N = MAXD * 2 * (MAXD - 2);
  localparam int WATCH_LIMIT = 5000;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [47:0]   in_tdata;   // operation, index, value_even, value_odd
  logic          in_tlast;   // last
  logic          out_tvalid;
  logic          out_tready;
  logic [7:0]    out_tdata;  // verdict
  logic          cfg_valid;
  logic          cfg_ready;
  logic [DW-1:0] cfg_data;   // dimension_in_use

  projected_pair_sign_test u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  longint inv_mem [INV_N];
  longint con_mem [CON_N];
  longint pair_even [MAXD];
  longint pair_odd [MAXD];
  bit     pair_known [MAXD];
  logic [DW-1:0] dim_reg;
  bit     verdict_q [$];
  int     fail_count;
  int     burst_left;
  int     idle_count;
  bit     hold_req;
  bit     hold_seen;
  int     hold_left;
  int     stall_left;
  int     stall_mode;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int dim_k();
    if (dim_reg < 2) return 2;
    if (dim_reg > MAXD) return MAXD;
    return dim_reg;
  endfunction

  function automatic int sgn(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic bit sign_test_verdict();
    int k;
    int cols;
    longint xa [MAXD];
    longint xb [MAXD];
    longint w;
    longint w1;
    int sr;
    int sr1;
    k = dim_k();
    cols = 2 * (k - 2);
    for (int i = 0; i < k; i++) begin
      xa[i] = 0;
      xb[i] = 0;
      for (int j = 0; j < k; j++) begin
        xa[i] += inv_mem[k * j + i] * pair_even[j];
        xb[i] += inv_mem[k * j + i] * pair_odd[j];
      end
    end
    sr = sgn(xa[k - 1]);
    sr1 = sgn(xb[k - 1]);
    for (int i = 0; i < cols; i++) begin
      w = 0;
      w1 = 0;
      for (int j = 0; j < k; j++) begin
        w += xa[j] * con_mem[cols * j + i];
        w1 += xb[j] * con_mem[cols * j + i];
      end
      if (sr * sgn(w) > 0 || sr1 * sgn(w1) > 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void apply_word(logic [1:0] op, logic [8:0] idx, logic signed [15:0] ve,
                                     logic signed [15:0] vo, logic lst);
    case (op)
      OP_INV: if (idx < INV_N) inv_mem[idx] = ve;
      OP_CON: if (idx < CON_N) con_mem[idx] = ve;
      OP_PAIR: begin
        if (idx < MAXD) begin
          pair_even[idx] = ve;
          pair_odd[idx] = vo;
          pair_known[idx] = 1'b1;
        end
        if (lst) verdict_q.push_back(sign_test_verdict());
      end
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [1:0] op, logic [8:0] idx, logic [15:0] ve,
                           logic [15:0] vo, logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, vo, ve, idx, op};
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    apply_word(op, idx, ve, vo, lst);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    go_idle();
    while (verdict_q.size() > 0) @(posedge clk);
    repeat (dim_k() * dim_k() + 2 * (dim_k() - 2) * dim_k() + 40) @(posedge clk);
  endtask

  task automatic write_dim(logic [DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dim_reg = val;
    @(posedge clk);
  endtask

  task automatic load_matrices();
    int k;
    k = dim_k();
    for (int a = 0; a < k * k; a++) send_word(OP_INV, 9'(a), pick_value(), 16'($urandom), 1'b0);
    for (int a = 0; a < 2 * (k - 2) * k; a++)
      send_word(OP_CON, 9'(a), pick_value(), 16'($urandom), 1'b0);
  endtask

  task automatic send_pairs();
    int k;
    int order [$];
    bit all_known;
    k = dim_k();
    for (int j = 0; j < k; j++) order.push_back(j);
    order.shuffle();
    all_known = 1'b1;
    for (int j = 0; j < k; j++) all_known &= pair_known[j];
    for (int n = 0; n < k; n++) begin
      if (all_known && $urandom_range(0, 15) == 0) begin
        send_word(OP_PAIR, 9'(n), pick_value(), pick_value(), 1'b1);
        return;
      end
      send_word(OP_PAIR, 9'(order[n]), pick_value(), pick_value(), n == k - 1);
    end
  endtask

  task automatic send_noise();
    bit all_known;
    all_known = 1'b1;
    for (int j = 0; j < dim_k(); j++) all_known &= pair_known[j];
    case ($urandom_range(0, 3))
      0: send_word(OP_NONE, 9'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      1: send_word(OP_PAIR, 9'($urandom_range(MAXD, 447)), 16'($urandom), 16'($urandom),
                   all_known);
      2: send_word(OP_INV, 9'($urandom_range(0, dim_k() * dim_k() - 1)), pick_value(),
                   16'($urandom), 1'b0);
      default: send_word(OP_INV, 9'($urandom_range(INV_N, 447)), 16'($urandom),
                         16'($urandom), 1'b0);
    endcase
  endtask

  task automatic test_directed();
    write_dim(5'd3);
    for (int a = 0; a < 9; a++)
      send_word(OP_INV, 9'(a), (a % 2) ? 16'h8000 : 16'h7fff, 16'h0000, 1'b0);
    for (int a = 0; a < 6; a++)
      send_word(OP_CON, 9'(a), (a % 3) ? 16'h7fff : 16'h8000, 16'hffff, 1'b0);
    send_word(OP_CON, 9'd447, 16'h1234, 16'h0000, 1'b0);
    send_word(OP_INV, 9'd300, 16'h5555, 16'h0000, 1'b0);
    send_word(OP_NONE, 9'd1, 16'h7fff, 16'h7fff, 1'b1);
    send_word(OP_PAIR, 9'd0, 16'h7fff, 16'h8000, 1'b0);
    send_word(OP_PAIR, 9'd1, 16'h8000, 16'h7fff, 1'b0);
    send_word(OP_PAIR, 9'd2, 16'h0000, 16'h0001, 1'b1);
    send_word(OP_PAIR, 9'd400, 16'h1111, 16'h2222, 1'b1);
    send_word(OP_PAIR, 9'd2, 16'hffff, 16'h0000, 1'b1);
    drain();
  endtask

  task automatic test_dimension(logic [DW-1:0] dim, int vectors, bit reload);
    write_dim(dim);
    if (reload) load_matrices();
    for (int v = 0; v < vectors; v++) begin
      send_pairs();
      if ($urandom_range(0, 5) == 0) send_noise();
    end
    drain();
  endtask

  task automatic test_backpressure();
    write_dim(5'd3);
    load_matrices();
    hold_req = ~hold_req;
    for (int v = 0; v < 40; v++) send_pairs();
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: stall_left = 0;
        1: stall_left = $urandom_range(0, 1);
        default: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
      endcase
      out_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict word with nothing expected: %0d", out_tdata[0]);
        fail_count++;
      end else begin
        if (out_tdata[0] !== verdict_q[0]) begin
          $error("verdict: expected %0d, got %0d", verdict_q[0], out_tdata[0]);
          fail_count++;
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCH_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    stall_left = 0;
    stall_mode = 0;
    fail_count = 0;
    burst_left = 0;
    idle_count = 0;
    dim_reg = DIM_RESET;
    foreach (pair_known[j]) pair_known[j] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_dimension(5'd0, 40, 1'b1);
    test_dimension(5'd2, 30, 1'b0);
    test_dimension(5'd4, 40, 1'b1);
    test_dimension(5'd5, 30, 1'b1);
    test_backpressure();
    test_dimension(5'd3, 60, 1'b1);
    test_dimension(5'd16, 5, 1'b1);
    test_dimension(5'd31, 5, 1'b0);
    test_dimension(5'd1, 20, 1'b0);
    drain();
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
